FILE: hw/rtl/qwsr_pkg.sv
// ---------------------------------------------------------------------------
// qwsr_pkg
// Shared constants and types for the quarter-wave sine lookup unit.
// ---------------------------------------------------------------------------
package qwsr_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int FINE_BITS_DEF  = 4;
  localparam int OUT_BITS_DEF   = 16;

  // Table entry fields
  localparam int BASE_W  = 15;
  localparam int SLOPE_W = 8;
  localparam int FIX_W   = 16;
  localparam int ENTRY_W = BASE_W + SLOPE_W + FIX_W;

  // Interpolated magnitude: 2*base + sum/2 + carry
  localparam int SUM_W = SLOPE_W + 2;
  localparam int MAG_W = BASE_W + 2;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef struct packed {
    logic valid;
    logic negate;
  } qwsr_ctl_t;

endpackage

FILE: hw/rtl/qwsr_ram.sv
// ---------------------------------------------------------------------------
// qwsr_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ---------------------------------------------------------------------------
module qwsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/qwsr_interp.sv
// ---------------------------------------------------------------------------
// qwsr_interp
// Two pipeline stages: slope shift-and-add with fix-bit select, then the
// magnitude sum of base, halved slope term and rounding carry.
// ---------------------------------------------------------------------------
module qwsr_interp #(
  parameter int FINE_BITS = qwsr_pkg::FINE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  qwsr_pkg::qwsr_ctl_t            ctl_i,
  input  logic [FINE_BITS-1:0]           fine_i,
  input  logic [qwsr_pkg::ENTRY_W-1:0]   entry_i,
  output qwsr_pkg::qwsr_ctl_t            ctl_o,
  output logic [qwsr_pkg::MAG_W-1:0]     mag_o
);

  localparam int SUBSTEPS  = 1 << FINE_BITS;
  localparam int FIX_OFF   = (SUBSTEPS > qwsr_pkg::FIX_W) ? 0 : qwsr_pkg::FIX_W - SUBSTEPS;
  localparam int POS_W     = FINE_BITS + 6;
  localparam int FIX_IDX_W = $clog2(qwsr_pkg::FIX_W);
  localparam int SUM_W     = qwsr_pkg::SUM_W;
  localparam int MAG_W     = qwsr_pkg::MAG_W;

  logic [qwsr_pkg::BASE_W-1:0]  base;
  logic [qwsr_pkg::SLOPE_W-1:0] slope;
  logic [qwsr_pkg::FIX_W-1:0]   fix_word;

  logic [SUM_W-1:0]     sum_nxt;
  logic [POS_W-1:0]     fix_pos;
  logic [POS_W-1:0]     fix_diff;
  logic [FIX_IDX_W-1:0] fix_idx;
  logic                 fix_bit_nxt;

  qwsr_pkg::qwsr_ctl_t         s2_ctl_r;
  logic [qwsr_pkg::BASE_W-1:0] s2_base_r;
  logic [SUM_W-1:0]            s2_sum_r;
  logic                        s2_fix_r;

  qwsr_pkg::qwsr_ctl_t s3_ctl_r;
  logic [MAG_W-1:0]    s3_mag_r;
  logic [MAG_W-1:0]    mag_nxt;

  assign base     = entry_i[qwsr_pkg::ENTRY_W-1 -: qwsr_pkg::BASE_W];
  assign slope    = entry_i[qwsr_pkg::FIX_W +: qwsr_pkg::SLOPE_W];
  assign fix_word = entry_i[qwsr_pkg::FIX_W-1:0];

  // 2*slope, slope, slope/2 ... one term per fine bit, MSB first
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < FINE_BITS; k++) begin
      if (fine_i[FINE_BITS-1-k]) begin
        sum_nxt = sum_nxt + (SUM_W'({slope, 1'b0}) >> k);
      end
    end
  end

  // sub-step 0 takes the fix word MSB; sub-steps past the stored bits read zero
  assign fix_pos     = POS_W'(fine_i) + POS_W'(FIX_OFF);
  assign fix_diff    = POS_W'(qwsr_pkg::FIX_W - 1) - fix_pos;
  assign fix_idx     = fix_diff[FIX_IDX_W-1:0];
  assign fix_bit_nxt = (fix_pos < POS_W'(qwsr_pkg::FIX_W)) ? fix_word[fix_idx] : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    s2_base_r <= base;
    s2_sum_r  <= sum_nxt;
    s2_fix_r  <= fix_bit_nxt;
  end

  // halve with round-up, plus the fix bit
  assign mag_nxt = MAG_W'({s2_base_r, 1'b0}) + MAG_W'(s2_sum_r[SUM_W-1:1])
                 + MAG_W'(s2_fix_r) + MAG_W'(s2_sum_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_mag_r <= mag_nxt;
  end

  assign ctl_o = s3_ctl_r;
  assign mag_o = s3_mag_r;

endmodule

FILE: hw/rtl/quarter_wave_sine_rom_interp_unit.sv
// ---------------------------------------------------------------------------
// quarter_wave_sine_rom_interp_unit
// Quarter-wave sine table lookup with linear interpolation.
// ---------------------------------------------------------------------------
// Takes one transaction every clock: busy is never raised. A lookup gives its
// sample on out_sine_value with out_valid high after it has passed the table
// read, slope sum, magnitude add, and sign and output registers, in order; a
// table write gives nothing. The receiver cannot stall, so out_valid is a
// single-cycle strobe. The rate of one transaction per cycle is set by the
// single-port table RAM, which serves either one write or one lookup read in
// each cycle. Read only entries that have been written.
// ---------------------------------------------------------------------------
module quarter_wave_sine_rom_interp_unit #(
  parameter int PHASE_BITS = qwsr_pkg::PHASE_BITS_DEF,
  parameter int FINE_BITS  = qwsr_pkg::FINE_BITS_DEF,
  parameter int OUT_BITS   = qwsr_pkg::OUT_BITS_DEF,
  localparam int QBITS     = PHASE_BITS - 2,
  localparam int ABITS     = QBITS - FINE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [PHASE_BITS-1:0]         in_phase,
  input  logic [ABITS-1:0]              in_entry_index,
  input  logic [qwsr_pkg::BASE_W-1:0]   in_entry_base,
  input  logic [qwsr_pkg::SLOPE_W-1:0]  in_entry_delta,
  input  logic [qwsr_pkg::FIX_W-1:0]    in_entry_fix_bits,
  output logic                          out_valid,
  output logic signed [OUT_BITS-1:0]    out_sine_value
);

  localparam int DEPTH = 1 << ABITS;
  localparam int MAG_W = qwsr_pkg::MAG_W;
  localparam int EXT_W = (MAG_W > OUT_BITS) ? MAG_W : OUT_BITS;

  logic                         accept;
  logic                         wr_en;
  logic [QBITS-1:0]             qphase;
  logic [ABITS-1:0]             rd_addr;
  logic [ABITS-1:0]             ram_addr;
  logic [qwsr_pkg::ENTRY_W-1:0] ram_wr_data;
  logic [qwsr_pkg::ENTRY_W-1:0] ram_rd_data;

  qwsr_pkg::qwsr_ctl_t  s1_ctl_r;
  qwsr_pkg::qwsr_ctl_t  s1_ctl_nxt;
  logic [FINE_BITS-1:0] s1_fine_r;

  qwsr_pkg::qwsr_ctl_t mag_ctl;
  logic [MAG_W-1:0]    mag;
  logic [EXT_W-1:0]    mag_ext;
  logic [EXT_W-1:0]    signed_ext;

  logic                       out_valid_r;
  logic [OUT_BITS-1:0]        out_sine_value_r;
  logic [OUT_BITS-1:0]        out_sine_value_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign wr_en  = accept & (in_cmd == qwsr_pkg::CMD_WRITE);

  // odd quadrants run the quarter backwards
  assign qphase   = in_phase[PHASE_BITS-2] ? ~in_phase[QBITS-1:0] : in_phase[QBITS-1:0];
  assign rd_addr  = qphase[QBITS-1:FINE_BITS];
  assign ram_addr = wr_en ? in_entry_index : rd_addr;
  assign ram_wr_data = {in_entry_base, in_entry_delta, in_entry_fix_bits};

  qwsr_ram #(
    .WIDTH (qwsr_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .addr    (ram_addr),
    .wr_data (ram_wr_data),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    s1_ctl_nxt.valid  = accept & (in_cmd == qwsr_pkg::CMD_LOOKUP);
    s1_ctl_nxt.negate = in_phase[PHASE_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_fine_r <= qphase[FINE_BITS-1:0];
  end

  qwsr_interp #(
    .FINE_BITS (FINE_BITS)
  ) u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (s1_ctl_r),
    .fine_i  (s1_fine_r),
    .entry_i (ram_rd_data),
    .ctl_o   (mag_ctl),
    .mag_o   (mag)
  );

  // lower half-circle negates, result wraps to OUT_BITS
  assign mag_ext            = EXT_W'(mag);
  assign signed_ext         = mag_ctl.negate ? (EXT_W'(0) - mag_ext) : mag_ext;
  assign out_sine_value_nxt = signed_ext[OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mag_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_sine_value_r <= out_sine_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = out_sine_value_r;

endmodule

FILE: hw/rtl/qwsr_chk.sv
// ---------------------------------------------------------------------------
// qwsr_chk
// Port-level checks on the sine lookup unit, bound to the top level.
// ---------------------------------------------------------------------------
module qwsr_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_cmd,
  input logic out_valid
);

  // never holds off a transaction
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // every lookup produces a sample after the pipeline latency
  a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && in_cmd == qwsr_pkg::CMD_LOOKUP) |-> ##4 out_valid)
    else $error("lookup lost");

  // a table write produces no sample
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == qwsr_pkg::CMD_WRITE) |-> ##4 !out_valid)
    else $error("sample from table write");

  // no sample without a lookup behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_cmd == qwsr_pkg::CMD_LOOKUP, 4))
    else $error("spurious sample");

endmodule

bind quarter_wave_sine_rom_interp_unit qwsr_chk u_qwsr_chk (.*);
